[rtl/wia_pkg.sv]
// shared constants and types for the wide integer alu
package wia_pkg;

  localparam int unsigned OperandBitsDef = 128;
  localparam int unsigned HalfBits       = 64;
  localparam int unsigned CmdBits        = 3;
  localparam int unsigned ShBits         = 7;
  localparam int unsigned InDataBits     = 266;  // 3+64*4+7 = 266 -> 34 bytes = 272
  localparam int unsigned InTdataBits    = 272;
  localparam int unsigned OutTdataBits   = 128;

  typedef enum logic [2:0] {
    CMD_SEXT = 3'd0,
    CMD_NEG  = 3'd1,
    CMD_ADD  = 3'd2,
    CMD_SUB  = 3'd3,
    CMD_MUL  = 3'd4,
    CMD_SHL  = 3'd5,
    CMD_SHR  = 3'd6,
    CMD_SAR  = 3'd7
  } cmd_e;

  // classified work item handed from front to back
  typedef struct packed {
    cmd_e               cmd;
    logic [127:0]       a;
    logic [127:0]       b;
    logic [ShBits-1:0]  sh;
  } op_t;

endpackage

[rtl/wia_front.sv]
// front stage: unpacks a beat, cuts operands to width, registers it into a small queue
module wia_front import wia_pkg::*; #(
  parameter int unsigned OperandBits = OperandBitsDef,
  parameter int unsigned Depth       = 2
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic [InTdataBits-1:0]  in_data_i,
  output logic                    op_valid_o,
  input  logic                    op_ready_i,
  output op_t                     op_o
);
  localparam logic [127:0] Mask = (OperandBits >= 128) ? {128{1'b1}} :
                                  ((128'd1 << OperandBits) - 128'd1);
  localparam int unsigned PtrBits = (Depth > 1) ? $clog2(Depth) : 1;

  op_t                 mem_q [Depth];
  logic [PtrBits-1:0]  wr_q, rd_q;
  logic [PtrBits:0]    cnt_q;
  op_t                 op_in;
  logic                push, pop;

  always_comb begin
    op_in.cmd = cmd_e'(in_data_i[2:0]);
    op_in.a   = {in_data_i[66:3], in_data_i[130:67]} & Mask;
    op_in.b   = {in_data_i[194:131], in_data_i[258:195]} & Mask;
    op_in.sh  = in_data_i[265:259];
  end

  assign in_ready_o = (cnt_q != (PtrBits+1)'(Depth));
  assign op_valid_o = (cnt_q != '0);
  assign push = in_valid_i && in_ready_o;
  assign pop  = op_valid_o && op_ready_i;
  assign op_o = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= op_in;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) begin
        wr_q <= (wr_q == PtrBits'(Depth - 1)) ? '0 : wr_q + 1'b1;
      end
      if (pop) begin
        rd_q <= (rd_q == PtrBits'(Depth - 1)) ? '0 : rd_q + 1'b1;
      end
      cnt_q <= cnt_q + (PtrBits+1)'(push) - (PtrBits+1)'(pop);
    end
  end
endmodule

[rtl/wia_back.sv]
// back stage: three-stage execute pipeline with 32x32 partial products and output register
module wia_back import wia_pkg::*; #(
  parameter int unsigned OperandBits = OperandBitsDef
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          op_valid_i,
  output logic          op_ready_o,
  input  op_t           op_i,
  output logic          res_valid_o,
  input  logic          res_ready_i,
  output logic [127:0]  res_o
);
  localparam logic [127:0] Mask = (OperandBits >= 128) ? {128{1'b1}} :
                                  ((128'd1 << OperandBits) - 128'd1);

  // stage 1: non-multiply result or 32x32 partial products
  // stage 2: sum of products, or the stage 1 result passed on
  logic          v1_q, v2_q, ov_q;
  logic          m1_q;
  logic [127:0]  r1_q, r2_q, res_q;
  logic [63:0]   pp_q [10];
  logic          adv;

  // only the low 128 bits matter: a0..a3 x b0..b3 with i+j<=3
  logic [31:0]   aw [4], bw [4];
  logic [127:0]  r1_d, sext, fill, ashr;
  logic          sgn;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      aw[i] = op_i.a[32*i +: 32];
      bw[i] = op_i.b[32*i +: 32];
    end
    sgn  = op_i.a[OperandBits-1];
    sext = {{64{op_i.a[63]}}, op_i.a[63:0]};
    fill = ~(Mask >> op_i.sh) & Mask;
    ashr = (op_i.a >> op_i.sh) | (sgn ? fill : '0);
    case (op_i.cmd)
      CMD_SEXT: r1_d = sext;
      CMD_NEG:  r1_d = -op_i.a;
      CMD_ADD:  r1_d = op_i.a + op_i.b;
      CMD_SUB:  r1_d = op_i.a - op_i.b;
      CMD_SHL:  r1_d = op_i.a << op_i.sh;
      CMD_SHR:  r1_d = op_i.a >> op_i.sh;
      CMD_SAR:  r1_d = ashr;
      default:  r1_d = '0;
    endcase
  end

  // pipeline moves when the output slot is free or being drained
  assign adv        = !ov_q || res_ready_i;
  assign op_ready_o = adv;
  assign res_valid_o = ov_q;
  assign res_o       = res_q;

  logic [127:0] prod;
  always_comb begin
    prod = {64'd0, pp_q[0]}
         + {32'd0, pp_q[1], 32'd0} + {32'd0, pp_q[2], 32'd0}
         + {pp_q[3], 64'd0} + {pp_q[4], 64'd0} + {pp_q[5], 64'd0}
         + {pp_q[6][31:0], 96'd0} + {pp_q[7][31:0], 96'd0}
         + {pp_q[8][31:0], 96'd0} + {pp_q[9][31:0], 96'd0};
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      r1_q  <= r1_d;
      m1_q  <= (op_i.cmd == CMD_MUL);
      pp_q[0] <= 64'(aw[0]) * 64'(bw[0]);
      pp_q[1] <= 64'(aw[0]) * 64'(bw[1]);
      pp_q[2] <= 64'(aw[1]) * 64'(bw[0]);
      pp_q[3] <= 64'(aw[0]) * 64'(bw[2]);
      pp_q[4] <= 64'(aw[1]) * 64'(bw[1]);
      pp_q[5] <= 64'(aw[2]) * 64'(bw[0]);
      pp_q[6] <= 64'(aw[0]) * 64'(bw[3]);
      pp_q[7] <= 64'(aw[1]) * 64'(bw[2]);
      pp_q[8] <= 64'(aw[2]) * 64'(bw[1]);
      pp_q[9] <= 64'(aw[3]) * 64'(bw[0]);
      r2_q  <= m1_q ? prod : r1_q;
      res_q <= r2_q & Mask;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      ov_q <= 1'b0;
    end else if (adv) begin
      v1_q <= op_valid_i;
      v2_q <= v1_q;
      ov_q <= v2_q;
    end
  end
endmodule

[rtl/wide_integer_alu_unit.sv]
// top level of the 128-bit wide integer alu
// usage:
//   input beats arrive on s_axis (tdata packs cmd, a_hi, a_lo, b_hi, b_lo,
//   shift_amount from the low bit up); one result beat per input leaves on
//   m_axis (tdata packs res_hi, res_lo from the low bit up)
//   the front part unpacks and cuts operands into a two-entry queue; the back
//   part is a three-stage execute pipeline: stage one does add, subtract,
//   negate, sign-extend and shifts, or forms ten 32x32 partial products;
//   stage two sums the products; stage three is the output register
//   stage two passes the other results on; without stalls, throughput is
//   one beat per cycle, set by the pipelined multiplier; when m_axis_tready
//   is low with a result pending, the execute pipeline holds, the queue
//   fills, and s_axis_tready drops once the queue is full; nothing is lost
//   reset clears the queue and all valid flags; no result is pending after it
module wide_integer_alu_unit import wia_pkg::*; #(
  parameter int unsigned OperandBits = OperandBitsDef
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     s_axis_tvalid,
  output logic                     s_axis_tready,
  // cmd[2:0], a_hi[66:3], a_lo[130:67], b_hi[194:131], b_lo[258:195],
  // shift_amount[265:259], zero fill up to 272 bits
  input  logic [InTdataBits-1:0]   s_axis_tdata,
  output logic                     m_axis_tvalid,
  input  logic                     m_axis_tready,
  // res_hi[63:0], res_lo[127:64]
  output logic [OutTdataBits-1:0]  m_axis_tdata
);
  // front to back queue output
  logic          op_valid, op_ready;
  op_t           op;
  logic [127:0]  res;

  wia_front #(.OperandBits(OperandBits), .Depth(2)) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_data_i  (s_axis_tdata),
    .op_valid_o (op_valid),
    .op_ready_i (op_ready),
    .op_o       (op)
  );

  wia_back #(.OperandBits(OperandBits)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .op_valid_i  (op_valid),
    .op_ready_o  (op_ready),
    .op_i        (op),
    .res_valid_o (m_axis_tvalid),
    .res_ready_i (m_axis_tready),
    .res_o       (res)
  );

  // swap halves into the stream layout: res_hi first
  assign m_axis_tdata = {res[63:0], res[127:64]};
endmodule
